### design/bhm_pkg.sv
// ----------------------------------------------------------------------------
// bhm_pkg
// Shared constants, codes and control types of the bucketed hash map engine.
// ----------------------------------------------------------------------------
package bhm_pkg;

  // BUCKETS must be a power of two so that the bucket is the low hash bits.
  localparam int BUCKETS     = 1024;
  localparam int BUCKET_WAYS = 4;
  localparam int BUCKET_BITS = $clog2(BUCKETS);
  localparam int WAY_BITS    = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
  localparam int COUNT_W     = 13;

  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_INDEX  = 3'd1;
  localparam logic [2:0] KIND_FIND   = 3'd2;
  localparam logic [2:0] KIND_ERASE  = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_FOUND   = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic CFG_MULTIPLIER = 1'b0;
  localparam logic CFG_OFFSET     = 1'b1;

  typedef enum logic [3:0] {
    S_SWEEP = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  typedef struct packed {
    logic accept;
    logic sweep_step;
    logic rd;
    logic exec;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic sweep_last;
    logic out_free;
  } ctl_stat_t;

endpackage

### design/bucketed_hash_map_engine_unit.sv
// ----------------------------------------------------------------------------
// bucketed_hash_map_engine_unit
// Hash map of signed 32-bit keys with bucketed ways and one result per request.
// ----------------------------------------------------------------------------
// A request passes through accept with the bucket hash, one read of the
// bucket row, and compare with write-back into the result register. A clear
// request sweeps every bucket row once before its result is written. After
// reset the same sweep runs with in_ready low; configuration writes are
// taken at any time.
module bucketed_hash_map_engine_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  kind,
  input  logic signed [31:0]          key,
  input  logic signed [31:0]          value_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  status,
  output logic signed [31:0]          value_out,
  output logic [bhm_pkg::COUNT_W-1:0] entry_count
);
  import bhm_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  bhm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bhm_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .kind        (kind),
    .key         (key),
    .value_in    (value_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .value_out   (value_out),
    .entry_count (entry_count),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

### design/bhm_ctrl.sv
// ----------------------------------------------------------------------------
// bhm_ctrl
// Sequencer of the hash map: clearing sweep, bucket read and commit.
// ----------------------------------------------------------------------------
module bhm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bhm_pkg::ctl_stat_t stat,
  output bhm_pkg::ctl_cmd_t  cmd
);
  import bhm_pkg::*;

  state_t state, state_next;
  logic   pending, pending_next;

  always_comb begin
    state_next   = state;
    pending_next = pending;
    cmd          = '0;
    case (state)
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_next   = pending ? S_EXEC : S_IDLE;
          pending_next = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.in_clear) begin
            state_next   = S_SWEEP;
            pending_next = 1'b1;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_SWEEP;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_SWEEP;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
    end
  end

endmodule

### design/bhm_datapath.sv
// ----------------------------------------------------------------------------
// bhm_datapath
// Request registers, hash, bucket memories, way compare and result register.
// ----------------------------------------------------------------------------
module bhm_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic [2:0]                 kind,
  input  logic signed [31:0]         key,
  input  logic signed [31:0]         value_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 status,
  output logic signed [31:0]         value_out,
  output logic [bhm_pkg::COUNT_W-1:0] entry_count,
  input  bhm_pkg::ctl_cmd_t          cmd,
  output bhm_pkg::ctl_stat_t         stat
);
  import bhm_pkg::*;

  logic [31:0] hash_multiplier, hash_offset;

  logic [2:0]             kind_q;
  logic [31:0]            key_q, val_q;
  logic [BUCKET_BITS-1:0] bucket_q, sweep_cnt;
  logic [COUNT_W-1:0]     count;

  logic [BUCKET_WAYS-1:0]            valid_mem [BUCKETS];
  logic [BUCKET_WAYS-1:0][31:0]      key_mem   [BUCKETS];
  logic [BUCKET_WAYS-1:0][31:0]      val_mem   [BUCKETS];
  logic [BUCKET_WAYS-1:0]            vrow;
  logic [BUCKET_WAYS-1:0][31:0]      krow, drow;

  logic [2*BUCKET_BITS-1:0] prod;
  logic [BUCKET_BITS-1:0]   bucket_in;

  logic                         hit, free;
  logic [WAY_BITS-1:0]          hit_way, free_way;
  logic [2:0]                   st;
  logic [31:0]                  vo;
  logic [COUNT_W-1:0]           count_next;
  logic                         wr_en;
  logic [BUCKET_WAYS-1:0]       vrow_next;
  logic [BUCKET_WAYS-1:0][31:0] krow_next, drow_next;
  logic                         mem_we;
  logic [BUCKET_BITS-1:0]       mem_addr;

  assign prod      = key[BUCKET_BITS-1:0] * hash_multiplier[BUCKET_BITS-1:0];
  assign bucket_in = prod[BUCKET_BITS-1:0] + hash_offset[BUCKET_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_multiplier <= 32'd1;
      hash_offset     <= 32'd1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MULTIPLIER) hash_multiplier <= cfg_data;
      else hash_offset <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q   <= kind;
      key_q    <= key;
      val_q    <= value_in;
      bucket_q <= bucket_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sweep_cnt <= '0;
    else if (cmd.sweep_step) sweep_cnt <= sweep_cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      vrow <= valid_mem[bucket_q];
      krow <= key_mem[bucket_q];
      drow <= val_mem[bucket_q];
    end
  end

  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = BUCKET_WAYS - 1; w >= 0; w--) begin
      if (vrow[w] && krow[w] == key_q) begin
        hit     = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (!vrow[w]) begin
        free     = 1'b1;
        free_way = WAY_BITS'(w);
      end
    end
  end

  always_comb begin
    st         = ST_DONE;
    vo         = '0;
    count_next = count;
    wr_en      = 1'b0;
    vrow_next  = vrow;
    krow_next  = krow;
    drow_next  = drow;
    case (kind_q)
      KIND_INSERT, KIND_INDEX: begin
        if (hit) begin
          if (kind_q == KIND_INSERT) begin
            st = ST_PRESENT;
          end else begin
            st = ST_FOUND;
            vo = drow[hit_way];
          end
        end else if (free) begin
          wr_en               = 1'b1;
          vrow_next[free_way] = 1'b1;
          krow_next[free_way] = key_q;
          drow_next[free_way] = (kind_q == KIND_INSERT) ? val_q : 32'd0;
          count_next          = count + 1'b1;
        end else begin
          st = ST_FULL;
        end
      end
      KIND_FIND: begin
        if (hit) begin
          st = ST_FOUND;
          vo = drow[hit_way];
        end else begin
          st = ST_MISSING;
        end
      end
      KIND_ERASE: begin
        if (hit) begin
          wr_en              = 1'b1;
          vrow_next[hit_way] = 1'b0;
          count_next         = count - 1'b1;
        end else begin
          st = ST_MISSING;
        end
      end
      KIND_CLEAR: count_next = '0;
      default: st = ST_DONE;
    endcase
  end

  assign mem_we   = cmd.sweep_step || (cmd.exec && wr_en);
  assign mem_addr = cmd.sweep_step ? sweep_cnt : bucket_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      valid_mem[mem_addr] <= cmd.sweep_step ? '0 : vrow_next;
    end
    if (cmd.exec && wr_en) begin
      key_mem[bucket_q] <= krow_next;
      val_mem[bucket_q] <= drow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      count     <= count_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status      <= st;
      value_out   <= vo;
      entry_count <= count_next;
    end
  end

  assign stat.in_clear   = (kind == KIND_CLEAR);
  assign stat.sweep_last = (sweep_cnt == {BUCKET_BITS{1'b1}});
  assign stat.out_free   = !out_valid || out_ready;

endmodule

### design/bhm_checker.sv
// ----------------------------------------------------------------------------
// bhm_checker
// Port-level assertions for the bucketed hash map engine.
// ----------------------------------------------------------------------------
module bhm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [2:0]                  status,
  input logic [31:0]                 value_out,
  input logic [bhm_pkg::COUNT_W-1:0] entry_count
);
  import bhm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(value_out)
      && $stable(entry_count))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new transaction taken while one is in progress");

  a_sweep_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("ready during the clearing sweep");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= COUNT_W'(BUCKETS * BUCKET_WAYS))
    else $error("entry count above capacity");

endmodule

bind bucketed_hash_map_engine_unit bhm_checker u_bhm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .value_out   (value_out),
  .entry_count (entry_count)
);

### dv/bucketed_hash_map_engine_checker.sv
// ----------------------------------------------------------------------------
// bucketed_hash_map_engine_checker
// Watches the request, result and register channels of the hash map engine,
// keeps its own copy of the map to predict each result, and compares every
// result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bucketed_hash_map_engine_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [2:0]                  kind,
  input  logic signed [31:0]          key,
  input  logic signed [31:0]          value_in,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [2:0]                  status,
  input  logic signed [31:0]          value_out,
  input  logic [bhm_pkg::COUNT_W-1:0] entry_count,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bhm_pkg::*;

  localparam int SLOTS = BUCKETS * BUCKET_WAYS;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        value;
    logic [COUNT_W-1:0] count;
  } map_result_t;

  logic [31:0]        map_mult;
  logic [31:0]        map_off;
  logic [31:0]        map_keys [SLOTS];
  logic [31:0]        map_vals [SLOTS];
  logic               map_used [SLOTS];
  logic [COUNT_W-1:0] map_count;
  map_result_t        awaited_results[$];

  function automatic map_result_t apply_request(logic [2:0] k, logic [31:0] kv,
                                                logic [31:0] v);
    map_result_t r;
    logic [63:0] h;
    int base;
    int hit;
    int free;
    r.status = ST_DONE;
    r.value  = '0;
    h = {{32{kv[31]}}, kv} * {32'd0, map_mult} + {32'd0, map_off};
    base = int'(h % BUCKETS) * BUCKET_WAYS;
    hit = -1;
    free = -1;
    for (int w = BUCKET_WAYS - 1; w >= 0; w--) begin
      if (map_used[base + w] && map_keys[base + w] == kv) hit = base + w;
      if (!map_used[base + w]) free = base + w;
    end
    case (k)
      KIND_INSERT, KIND_INDEX: begin
        if (hit >= 0) begin
          if (k == KIND_INSERT) begin
            r.status = ST_PRESENT;
          end else begin
            r.status = ST_FOUND;
            r.value  = map_vals[hit];
          end
        end else if (free < 0) begin
          r.status = ST_FULL;
        end else begin
          map_keys[free] = kv;
          map_vals[free] = (k == KIND_INSERT) ? v : '0;
          map_used[free] = 1'b1;
          map_count++;
        end
      end
      KIND_FIND: begin
        if (hit >= 0) begin
          r.status = ST_FOUND;
          r.value  = map_vals[hit];
        end else begin
          r.status = ST_MISSING;
        end
      end
      KIND_ERASE: begin
        if (hit >= 0) begin
          map_used[hit] = 1'b0;
          map_count--;
        end else begin
          r.status = ST_MISSING;
        end
      end
      KIND_CLEAR: begin
        for (int s = 0; s < SLOTS; s++) map_used[s] = 1'b0;
        map_count = '0;
      end
      default: ;
    endcase
    r.count = map_count;
    return r;
  endfunction

  assign pending = awaited_results.size();

  initial errors = 0;

  always @(posedge clk) begin
    map_result_t want;
    if (rst) begin
      map_mult  = 32'd1;
      map_off   = 32'd1;
      map_count = '0;
      for (int s = 0; s < SLOTS; s++) map_used[s] = 1'b0;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MULTIPLIER) map_mult = cfg_data;
        else map_off = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          if (errors < 10)
            $display("Unexpected result transaction: status %0d value %0d count %0d",
                     status, value_out, entry_count);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (want.status !== status || want.value !== value_out ||
              want.count !== entry_count) begin
            if (errors < 10)
              $display("Mismatch: expected status %0d value %0d count %0d, got %0d %0d %0d",
                       want.status, $signed(want.value), want.count,
                       status, value_out, entry_count);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        awaited_results.insert(awaited_results.size(),
                               apply_request(kind, key, value_in));
    end
  end
endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives directed and random map requests into the hash map engine under
// several hash settings and handshake pressures; the checker beside the block
// predicts and compares the results, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bhm_pkg::*;

  localparam int QUIET_LIMIT = 6000;
  localparam int PHASE_ITEMS = 410;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic                cfg_index;
  logic [31:0]         cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic [2:0]          kind;
  logic signed [31:0]  key;
  logic signed [31:0]  value_in;
  logic                out_valid;
  logic                out_ready;
  logic [2:0]          status;
  logic signed [31:0]  value_out;
  logic [COUNT_W-1:0]  entry_count;
  int                  errors;
  int                  pending;

  int          send_idle;
  int          recv_idle;
  logic [31:0] key_pool [64];

  bucketed_hash_map_engine_unit dut (.*);

  bucketed_hash_map_engine_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_MULTIPLIER;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = KIND_INSERT;
    key = '0;
    value_in = '0;
    send_idle = 33;
    recv_idle = 72;
  end

  initial begin
    int seen;
    int hold_left;
    bit hold_done;
    seen = 0;
    hold_left = 0;
    hold_done = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) seen++;
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && seen >= 1000) begin
        hold_done = 1;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_request(logic [2:0] k, logic [31:0] kv, logic [31:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    key      <= kv;
    value_in <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic random_requests(int n);
    logic [2:0]  k;
    logic [31:0] kv;
    int pick;
    for (int s = 0; s < 64; s++)
      key_pool[s] = $urandom_range(7) + 32'd1024 * ($urandom_range(9) - 4) +
                    (($urandom_range(3) == 0) ? $urandom : 32'd0);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 30) k = KIND_INSERT;
      else if (pick < 50) k = KIND_INDEX;
      else if (pick < 75) k = KIND_FIND;
      else if (pick < 95) k = KIND_ERASE;
      else if (pick < 96) k = KIND_CLEAR;
      else k = 3'($urandom_range(7, 5));
      kv = ($urandom_range(9) < 8) ? key_pool[$urandom_range(63)] : $urandom;
      send_request(k, kv, $urandom);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_request(KIND_INSERT, 32'd0, 32'h7fff_ffff);
    send_request(KIND_INSERT, 32'd0, 32'h1234_5678);
    send_request(KIND_FIND, 32'd0, 32'd0);
    send_request(KIND_INDEX, 32'd0, 32'd0);
    send_request(KIND_INDEX, 32'd5, 32'hffff_ffff);
    send_request(KIND_FIND, 32'd5, 32'd0);
    send_request(KIND_FIND, 32'd99, 32'd0);
    send_request(KIND_ERASE, 32'd99, 32'd0);
    send_request(KIND_ERASE, 32'd0, 32'd0);
    send_request(KIND_INSERT, 32'd3, 32'h8000_0000);
    send_request(KIND_INSERT, 32'd1027, 32'd1);
    send_request(KIND_INSERT, 32'd2051, 32'd2);
    send_request(KIND_INSERT, -32'sd1021, 32'd3);
    send_request(KIND_INSERT, 32'd3075, 32'd4);
    send_request(KIND_INDEX, 32'd4099, 32'd0);
    send_request(KIND_INSERT, 32'h7fff_ffff, 32'h8000_0000);
    send_request(KIND_INSERT, 32'h8000_0000, 32'h7fff_ffff);
    send_request(KIND_INSERT, 32'hffff_ffff, 32'h5555_aaaa);
    send_request(KIND_FIND, 32'hffff_ffff, 32'd0);
    send_request(3'd5, 32'd3, 32'd0);
    send_request(3'd6, 32'd0, 32'd0);
    send_request(3'd7, 32'd5, 32'd0);
    send_request(KIND_CLEAR, 32'd0, 32'd0);
    send_request(KIND_FIND, 32'd3, 32'd0);

    random_requests(PHASE_ITEMS);
    drain();

    send_idle = 72;
    recv_idle = 33;
    write_reg(CFG_MULTIPLIER, 32'hffff_ffff);
    write_reg(CFG_OFFSET, 32'hffff_ffff);
    random_requests(PHASE_ITEMS);
    drain();

    send_idle = 0;
    recv_idle = 0;
    write_reg(CFG_MULTIPLIER, $urandom | 32'd1);
    write_reg(CFG_OFFSET, $urandom);
    random_requests(PHASE_ITEMS);
    drain();

    write_reg(CFG_MULTIPLIER, 32'd1);
    write_reg(CFG_OFFSET, 32'd1);
    random_requests(PHASE_ITEMS);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

### sim.f
design/bhm_pkg.sv
design/bhm_ctrl.sv
design/bhm_datapath.sv
design/bucketed_hash_map_engine_unit.sv
design/bhm_checker.sv
dv/bucketed_hash_map_engine_checker.sv
dv/tb.sv
